>>> rtl/core/radr_pkg.sv
// Package for the rectangle density raster: item, result and memory request
// types, item kinds, register indexes and the sequencer state. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package radr_pkg;

	localparam int unsigned SUM_W = 56;
	localparam int unsigned CRD_W = 24;
	localparam int unsigned POS_W = 27;
	localparam int unsigned DIV_W = 26;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_BIN_WIDTH  = 3'd0,
		REG_BIN_HEIGHT = 3'd1,
		REG_GRID_COLS  = 3'd2,
		REG_GRID_ROWS  = 3'd3,
		REG_INCL_TERM  = 3'd4
	} reg_index_t;

	localparam logic [1:0] PLANE_TERMINAL = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  plane;
		logic [23:0] center_x;
		logic [23:0] center_y;
		logic [23:0] size_x;
		logic [23:0] size_y;
		logic [19:0] margin;
		logic [6:0]  read_col;
		logic [6:0]  read_row;
	} item_t;

	typedef struct packed {
		logic [6:0]  first_col;
		logic [6:0]  first_row;
		logic [6:0]  last_col;
		logic [6:0]  last_row;
		logic [55:0] bin_value;
		logic        saturated;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_BOUNDS,
		ST_ROWPREP,
		ST_OY,
		ST_MUL,
		ST_RD,
		ST_WB,
		ST_CLEAR,
		ST_READ,
		ST_READWAIT,
		ST_DONE
	} state_t;

	// Memory request from the sequencer to the density memory.
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/rect_area_density_raster.sv
// Top level of the rectangle density raster: sequencer, divider and memory.
// Depends on radr_pkg, radr_div and radr_mem.
`timescale 1ns / 1ps
`default_nettype none
// Usage: an item is taken on start while busy is low. It is an add, a clear,
// a read or a no-op; each gives exactly one result, shown on res with res_valid
// high for one cycle. The receiver cannot stall; the block holds busy high until
// the result has been shown, so one item is in work at a time.
// Add: four bin index divisions, one after another on one shared divider, then
// per column a row preparation step and per covered bin overlap, multiply and
// read, read wait and read-modify-write against the single memory port.
// Clear: one bin of the plane per cycle, over all MAX_COLS*MAX_ROWS bins.
// Read: a memory read and a wait for the registered read data. Configuration
// writes on cfg_valid/cfg_ready are taken at any time; cfg_ready is high always
// and should only be used when idle. After reset the block runs a clearing pass
// over the whole memory, one entry a cycle, with busy high.
module rect_area_density_raster
	import radr_pkg::*;
#(
	parameter int unsigned MAX_COLS = 128,
	parameter int unsigned MAX_ROWS = 128,
	parameter int unsigned PLANES   = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             res_valid,
	output result_t          res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned PW    = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int unsigned DEPTH = PLANES * MAX_COLS * MAX_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned PLW   = $clog2(MAX_COLS * MAX_ROWS);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// configuration
	logic [23:0] bw_q, bh_q;
	logic [7:0]  gc_q, gr_q;
	logic        it_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= 24'd256;
			bh_q <= 24'd256;
			gc_q <= 8'd128;
			gr_q <= 8'd128;
			it_q <= 1'b1;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_BIN_WIDTH:  bw_q <= cfg_data;
				REG_BIN_HEIGHT: bh_q <= cfg_data;
				REG_GRID_COLS:  gc_q <= cfg_data[7:0];
				REG_GRID_ROWS:  gr_q <= cfg_data[7:0];
				REG_INCL_TERM:  it_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// used grid size minus one, at 11 bits
	logic [10:0] cols_m1, rows_m1;
	always_comb begin
		if (gc_q == 8'd0) cols_m1 = '0;
		else if (11'(gc_q) > 11'(MAX_COLS)) cols_m1 = 11'(MAX_COLS - 1);
		else cols_m1 = 11'(gc_q) - 11'd1;
		if (gr_q == 8'd0) rows_m1 = '0;
		else if (11'(gr_q) > 11'(MAX_ROWS)) rows_m1 = 11'(MAX_ROWS - 1);
		else rows_m1 = 11'(gr_q) - 11'd1;
	end

	logic [25:0] wx2, wy2;
	assign wx2 = {1'b0, ((bw_q == '0) ? 24'd1 : bw_q), 1'b0};
	assign wy2 = {1'b0, ((bh_q == '0) ? 24'd1 : bh_q), 1'b0};

	// item registers
	state_t      state_q, state_d;
	logic [1:0]  kind_q, plane_q;
	logic        acc_q;
	logic signed [POS_W:0] x0_q, x1_q, y0_q, y1_q;
	logic [1:0]  dsel_q;
	logic [CW-1:0] fc_q, lc_q, c_q;
	logic [RW-1:0] fr_q, lr_q, r_q;
	logic [25:0] ox_q, oy_q;
	logic [51:0] area_q;
	logic [51:0] prod;
	logic        sat_q;
	logic [SUM_W-1:0] val_q;
	logic [AW:0] clr_q;
	logic        init_q;

	// divider
	logic        dgo, ddone;
	logic [25:0] dnum, dden, dquo;
	logic signed [POS_W:0] dpos;
	always_comb begin
		case (dsel_q)
			2'd0: dpos = x0_q;
			2'd1: dpos = x1_q;
			2'd2: dpos = y0_q;
			default: dpos = y1_q;
		endcase
	end
	assign dnum = dpos[POS_W] ? '0 : dpos[25:0];
	assign dden = dsel_q[1] ? wy2 : wx2;

	radr_div u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .dividend(dnum), .divisor(dden),
		.done(ddone), .quotient(dquo)
	);

	logic [CW-1:0] qc;
	logic [RW-1:0] qr;
	always_comb begin
		if (dpos[POS_W]) qc = '0;
		else if (dquo > 26'(cols_m1)) qc = CW'(cols_m1);
		else qc = dquo[CW-1:0];
		if (dpos[POS_W]) qr = '0;
		else if (dquo > 26'(rows_m1)) qr = RW'(rows_m1);
		else qr = dquo[RW-1:0];
	end

	// overlap of [lo,hi] with bin k of step s, all at doubled scale
	function automatic logic [25:0] ovl(input logic signed [POS_W:0] lo,
		input logic signed [POS_W:0] hi, input logic [34:0] blo,
		input logic [25:0] s);
		logic signed [36:0] a, b, bl, bh;
		begin
			bl = {2'b00, blo};
			bh = bl + 37'(s);
			a  = (37'(lo) > bl) ? 37'(lo) : bl;
			b  = (37'(hi) < bh) ? 37'(hi) : bh;
			ovl = (b > a) ? 26'(b - a) : '0;
		end
	endfunction

	logic [34:0] cbase, rbase;
	logic [SUM_W-1:0] rdata;
	logic [SUM_W:0]   sum;
	logic [AW-1:0] addr;
	mem_ctl_t      mctl;
	logic [SUM_W-1:0] wdata;
	logic [6:0] rcol, rrow;

	assign prod = ox_q * oy_q;
	assign sum = {1'b0, rdata} + {5'b0, area_q};
	always_comb begin
		rcol = (11'(item.read_col) > cols_m1) ? 7'(cols_m1) : item.read_col;
		rrow = (11'(item.read_row) > rows_m1) ? 7'(rows_m1) : item.read_row;
	end

	// cell(plane, col, row) = (plane*MAX_ROWS + row)*MAX_COLS + col
	logic [AW-1:0] cell_addr;
	assign cell_addr = AW'((32'(plane_q) * MAX_ROWS + 32'(r_q)) * MAX_COLS
		+ 32'(c_q));

	always_comb begin
		state_d = state_q;
		dgo = 1'b0;
		mctl = '0;
		addr = cell_addr;
		wdata = '0;
		cbase = 35'(c_q) * 35'(wx2);
		rbase = 35'(r_q) * 35'(wy2);
		case (state_q)
			ST_IDLE: if (start) begin
				case (kind_t'(item.kind))
					KIND_ADD:   state_d = ST_DIV;
					KIND_CLEAR: state_d = ST_CLEAR;
					KIND_READ:  state_d = ST_READ;
					default:    state_d = ST_DONE;
				endcase
			end
			// Each division is launched from here so that the operand mux already
			// follows the updated edge select.
			ST_DIV: begin
				dgo = 1'b1;
				state_d = ST_BOUNDS;
			end
			ST_BOUNDS: if (ddone) begin
				if (dsel_q != 2'd3) state_d = ST_DIV;
				else state_d = acc_q ? ST_ROWPREP : ST_DONE;
			end
			ST_ROWPREP: state_d = ST_OY;
			ST_OY: state_d = ST_MUL;
			ST_MUL: begin
				mctl.rd = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: state_d = ST_WB;
			ST_WB: begin
				mctl.wr = 1'b1;
				wdata = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
				if (r_q != lr_q) state_d = ST_OY;
				else if (c_q != lc_q) state_d = ST_ROWPREP;
				else state_d = ST_DONE;
			end
			ST_CLEAR: begin
				mctl.wr = init_q || (32'(plane_q) < PLANES);
				addr = init_q ? clr_q[AW-1:0]
					: AW'((32'(plane_q) * MAX_ROWS * MAX_COLS) + 32'(clr_q[PLW-1:0]));
				if (init_q ? (32'(clr_q) == DEPTH - 1)
					: (32'(clr_q) == MAX_COLS * MAX_ROWS - 1)) state_d = init_q ? ST_IDLE : ST_DONE;
			end
			ST_READ: begin
				mctl.rd = 32'(plane_q) < PLANES;
				state_d = ST_READWAIT;
			end
			ST_READWAIT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	radr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .ctl(mctl), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			init_q  <= 1'b1;
			clr_q   <= '0;
			dsel_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (state_q == ST_CLEAR && state_d != ST_CLEAR) init_q <= 1'b0;
			if (state_q == ST_IDLE) dsel_q <= '0;
			else if (state_q == ST_BOUNDS && ddone) dsel_q <= dsel_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				kind_q  <= item.kind;
				plane_q <= item.plane;
				acc_q   <= (32'(item.plane) < PLANES) &&
					!(item.plane == PLANE_TERMINAL && !it_q);
				x0_q <= 28'(2 * 28'(item.center_x)) - 28'(item.size_x) - 28'(item.margin);
				x1_q <= 28'(2 * 28'(item.center_x)) + 28'(item.size_x) + 28'(item.margin);
				y0_q <= 28'(2 * 28'(item.center_y)) - 28'(item.size_y) - 28'(item.margin);
				y1_q <= 28'(2 * 28'(item.center_y)) + 28'(item.size_y) + 28'(item.margin);
				sat_q <= 1'b0;
				val_q <= '0;
				fc_q <= '0; lc_q <= '0; fr_q <= '0; lr_q <= '0;
				if (kind_t'(item.kind) == KIND_READ) begin
					c_q <= CW'(rcol); r_q <= RW'(rrow);
					fc_q <= CW'(rcol); lc_q <= CW'(rcol);
					fr_q <= RW'(rrow); lr_q <= RW'(rrow);
				end
			end
			ST_BOUNDS: if (ddone) begin
				case (dsel_q)
					2'd0: begin fc_q <= qc; c_q <= qc; end
					2'd1: lc_q <= qc;
					2'd2: fr_q <= qr;
					default: lr_q <= qr;
				endcase
			end
			ST_ROWPREP: begin
				ox_q <= ovl(x0_q, x1_q, cbase, wx2);
				r_q  <= fr_q;
			end
			ST_OY: oy_q <= ovl(y0_q, y1_q, rbase, wy2);
			ST_MUL: area_q <= prod >> 2;
			ST_WB: begin
				if (sum[SUM_W]) sat_q <= 1'b1;
				if (r_q != lr_q) r_q <= r_q + 1'b1;
				else c_q <= c_q + 1'b1;
			end
			ST_READWAIT: if (32'(plane_q) < PLANES) val_q <= rdata;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	always_comb begin
		res = '0;
		if (kind_q == KIND_ADD || kind_q == KIND_READ) begin
			res.first_col = 7'(fc_q);
			res.last_col  = 7'(lc_q);
			res.first_row = 7'(fr_q);
			res.last_row  = 7'(lr_q);
		end
		res.bin_value = val_q;
		res.saturated = sat_q;
	end
endmodule
`default_nettype wire

>>> rtl/core/radr_div.sv
// Restoring divider, one quotient bit per cycle, for the bin index search.
// Depends on radr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module radr_div
	import radr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q, quo_q[DIV_W-1]};

	// done is raised by the same edge that shifts in the last quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			run_q  <= 1'b1;
			cnt_q  <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DIV_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> rtl/core/radr_mem.sv
// Density memory: one synchronous port, registered read data.
// Depends on radr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module radr_mem
	import radr_pkg::*;
#(
	parameter int unsigned DEPTH = 49152,
	parameter int unsigned AW    = 16
) (
	input  wire logic             clk,
	input  wire mem_ctl_t         ctl,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [SUM_W-1:0] wdata,
	output logic [SUM_W-1:0]      rdata
);
	logic [SUM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire
